/* sv/length_prefixed_request_deframer_core_assert.svh */
// Assertion macros for the length-prefixed request deframer.
`ifndef LENGTH_PREFIXED_REQUEST_DEFRAMER_CORE_ASSERT_SVH
`define LENGTH_PREFIXED_REQUEST_DEFRAMER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define LPRD_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("deframer check failed");

// Next-cycle implication, checked out of reset.
`define LPRD_ASSERT_NXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("deframer check failed");

`endif

/* sv/lprd_pkg.sv */
// Types and constants shared by the length-prefixed request deframer.
package lprd_pkg;

  localparam logic [31:0] MaxMsgDefault = 32'd32 << 20;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_COUNT,
    PH_SLEN,
    PH_SDATA,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    KIND_BODY_LEN,
    KIND_COUNT,
    KIND_STR_LEN,
    KIND_STR_DATA,
    KIND_TRAIL,
    KIND_DROP
  } kind_t;

  typedef enum logic [2:0] {
    VERD_PROGRESS,
    VERD_WELL,
    VERD_MALFORMED,
    VERD_OVERSIZE,
    VERD_DROPPED
  } verdict_t;

  typedef struct packed {
    phase_t      phase;
    logic [31:0] acc;
    logic [1:0]  fcnt;
    logic [31:0] body_left;
    logic [31:0] strings_left;
    logic [31:0] cur_string;
    logic [31:0] str_left;
    logic        overrun;
    logic        closed;
  } state_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] snum;
    logic        send;
    logic        mend;
    verdict_t    verdict;
  } result_t;

  localparam state_t StateClear = '{
    phase:        PH_HEADER,
    acc:          32'd0,
    fcnt:         2'd0,
    body_left:    32'd0,
    strings_left: 32'd0,
    cur_string:   32'd0,
    str_left:     32'd0,
    overrun:      1'b0,
    closed:       1'b0
  };

endpackage

/* sv/length_prefixed_request_deframer_core.sv */
// Length-prefixed request deframer: one request byte in, one tagged byte out, per cycle.
// Each accepted byte is tagged with its role in the message (body length, string count,
// string length, string data, trailing, dropped), the index of its string, string and
// message end marks and, on the byte that ends the body, the verdict. The block takes one
// byte every cycle while out_tready is high; with out_tready low the input stalls once the
// input and result registers both hold a byte. A byte's tags pass through the input
// register, then the result register; the next parser state is computed combinationally
// by 32-bit decrements and compares. Raising restart with a byte clears the parser
// before that byte. max_message_bytes resets to 32 MiB and is written on the cfg channel,
// which is always ready; write it only while no bytes are in flight.
`include "length_prefixed_request_deframer_core_assert.svh"

module length_prefixed_request_deframer_core (
  input  logic        clk,
  input  logic        rst_n,
  // request byte stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_in
  input  logic        in_tuser,   // [0] restart
  // tagged byte stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [7:0] byte_out, [39:8] string_number
  output logic [6:0]  out_tuser,  // [2:0] byte_kind, [3] string_end, [6:4] verdict
  output logic        out_tlast,  // message_end
  // max_message_bytes write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  logic              in_valid_r;
  logic [7:0]        in_byte_r;
  logic              in_restart_r;
  logic              advance;
  logic [31:0]       max_r;
  lprd_pkg::state_t  state_r;
  lprd_pkg::state_t  state_nxt;
  lprd_pkg::result_t res;
  logic              out_valid_r;
  logic [39:0]       out_tdata_r;
  logic [6:0]        out_tuser_r;
  logic              out_tlast_r;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= lprd_pkg::MaxMsgDefault;
    end else if (cfg_valid) begin
      max_r <= cfg_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r    <= in_tdata;
      in_restart_r <= in_tuser;
    end
  end

  lprd_step u_step (
    .state_i   (state_r),
    .byte_i    (in_byte_r),
    .restart_i (in_restart_r),
    .max_i     (max_r),
    .state_o   (state_nxt),
    .res_o     (res)
  );

  // Advance parser state only when the beat moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lprd_pkg::StateClear;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_tdata_r <= {res.snum, in_byte_r};
      out_tuser_r <= {3'(res.verdict), res.send, 3'(res.kind)};
      out_tlast_r <= res.mend;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  `LPRD_ASSERT_IMP(a_mend_has_verdict, out_valid_r && out_tlast_r,
    (out_tuser_r[6:4] == 3'(lprd_pkg::VERD_WELL)) ||
    (out_tuser_r[6:4] == 3'(lprd_pkg::VERD_MALFORMED)))
  `LPRD_ASSERT_IMP(a_send_on_data, out_valid_r && out_tuser_r[3],
    out_tuser_r[2:0] == 3'(lprd_pkg::KIND_STR_DATA))
  `LPRD_ASSERT_IMP(a_drop_verdict, out_valid_r && (out_tuser_r[2:0] == 3'(lprd_pkg::KIND_DROP)),
    out_tuser_r[6:4] == 3'(lprd_pkg::VERD_DROPPED))
  `LPRD_ASSERT_NXT(a_well_clears, advance && (res.verdict == lprd_pkg::VERD_WELL),
    (state_r.phase == lprd_pkg::PH_HEADER) && !state_r.closed && (state_r.fcnt == 2'd0))

endmodule

/* sv/lprd_step.sv */
// Per-byte parser step: next parser state and the tags for one byte.
module lprd_step (
  input  lprd_pkg::state_t  state_i,
  input  logic [7:0]        byte_i,
  input  logic              restart_i,
  input  logic [31:0]       max_i,
  output lprd_pkg::state_t  state_o,
  output lprd_pkg::result_t res_o
);

  lprd_pkg::state_t s;
  logic        field_done;
  logic [31:0] acc_new;
  logic [31:0] body_dec;
  logic        body_zero;
  logic [31:0] sl_dec;
  logic [31:0] sbl_dec;
  logic        strings_done;

  assign s          = restart_i ? lprd_pkg::StateClear : state_i;
  assign field_done = (s.fcnt == 2'd3);
  assign acc_new    = s.acc | (32'(byte_i) << {s.fcnt, 3'b000});
  assign body_dec   = s.body_left - 32'd1;
  assign body_zero  = (body_dec == 32'd0);
  assign sl_dec     = s.strings_left - 32'd1;
  assign sbl_dec    = s.str_left - 32'd1;

  // Strings become complete on this byte
  always_comb begin
    case (s.phase)
      lprd_pkg::PH_COUNT: strings_done = field_done && (acc_new == 32'd0);
      lprd_pkg::PH_SLEN:  strings_done = field_done && (acc_new == 32'd0) && (sl_dec == 32'd0);
      lprd_pkg::PH_SDATA: strings_done = (sbl_dec == 32'd0) && (sl_dec == 32'd0);
      default:            strings_done = 1'b0;
    endcase
  end

  always_comb begin
    state_o = s;
    if (s.closed) begin
      state_o = s;
    end else if (s.phase == lprd_pkg::PH_HEADER) begin
      state_o.fcnt = s.fcnt + 2'd1;
      state_o.acc  = field_done ? 32'd0 : acc_new;
      if (field_done) begin
        if ((acc_new > max_i) || (acc_new == 32'd0)) begin
          state_o.closed = 1'b1;
        end else begin
          state_o.body_left = acc_new;
          state_o.phase     = lprd_pkg::PH_COUNT;
        end
      end
    end else begin
      case (s.phase)
        lprd_pkg::PH_COUNT: begin
          state_o.fcnt = s.fcnt + 2'd1;
          state_o.acc  = field_done ? 32'd0 : acc_new;
          if (field_done) begin
            state_o.strings_left = acc_new;
            state_o.cur_string   = 32'd0;
            state_o.phase = (acc_new == 32'd0) ? lprd_pkg::PH_DONE : lprd_pkg::PH_SLEN;
          end
        end
        lprd_pkg::PH_SLEN: begin
          state_o.fcnt = s.fcnt + 2'd1;
          state_o.acc  = field_done ? 32'd0 : acc_new;
          if (field_done) begin
            state_o.str_left = acc_new;
            if (acc_new == 32'd0) begin
              state_o.cur_string   = s.cur_string + 32'd1;
              state_o.strings_left = sl_dec;
              state_o.phase = (sl_dec == 32'd0) ? lprd_pkg::PH_DONE : lprd_pkg::PH_SLEN;
            end else begin
              state_o.phase = lprd_pkg::PH_SDATA;
            end
          end
        end
        lprd_pkg::PH_SDATA: begin
          state_o.str_left = sbl_dec;
          if (sbl_dec == 32'd0) begin
            state_o.cur_string   = s.cur_string + 32'd1;
            state_o.strings_left = sl_dec;
            state_o.phase = (sl_dec == 32'd0) ? lprd_pkg::PH_DONE : lprd_pkg::PH_SLEN;
          end
        end
        default: begin
          state_o.overrun = 1'b1;
        end
      endcase
      state_o.body_left = body_dec;
      if (body_zero) begin
        if (strings_done && !s.overrun) begin
          state_o = lprd_pkg::StateClear;
        end else begin
          state_o.closed = 1'b1;
        end
      end
    end
  end

  always_comb begin
    res_o.kind    = lprd_pkg::KIND_BODY_LEN;
    res_o.snum    = 32'd0;
    res_o.send    = 1'b0;
    res_o.mend    = 1'b0;
    res_o.verdict = lprd_pkg::VERD_PROGRESS;
    if (s.closed) begin
      res_o.kind    = lprd_pkg::KIND_DROP;
      res_o.verdict = lprd_pkg::VERD_DROPPED;
    end else if (s.phase == lprd_pkg::PH_HEADER) begin
      if (field_done) begin
        if (acc_new > max_i) begin
          res_o.verdict = lprd_pkg::VERD_OVERSIZE;
        end else if (acc_new == 32'd0) begin
          res_o.mend    = 1'b1;
          res_o.verdict = lprd_pkg::VERD_MALFORMED;
        end
      end
    end else begin
      case (s.phase)
        lprd_pkg::PH_COUNT: res_o.kind = lprd_pkg::KIND_COUNT;
        lprd_pkg::PH_SLEN: begin
          res_o.kind = lprd_pkg::KIND_STR_LEN;
          res_o.snum = s.cur_string;
        end
        lprd_pkg::PH_SDATA: begin
          res_o.kind = lprd_pkg::KIND_STR_DATA;
          res_o.snum = s.cur_string;
          res_o.send = (sbl_dec == 32'd0);
        end
        default: res_o.kind = lprd_pkg::KIND_TRAIL;
      endcase
      if (body_zero) begin
        res_o.mend    = 1'b1;
        res_o.verdict = (strings_done && !s.overrun) ? lprd_pkg::VERD_WELL
                                                     : lprd_pkg::VERD_MALFORMED;
      end
    end
  end

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the length-prefixed request deframer core.
module testbench;

  localparam int IdleLimit   = 2000;
  localparam int DrainCycles = 6;
  localparam int ReportCap   = 100;

  typedef enum {FLAW_NONE, FLAW_TRAIL, FLAW_SHORT, FLAW_COUNT, FLAW_LENGTH} flaw_t;

  typedef struct {
    logic [7:0]         data;
    lprd_pkg::kind_t    kind;
    logic [31:0]        idx;
    logic               str_last;
    logic               msg_last;
    lprd_pkg::verdict_t verd;
  } tag_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic [7:0]  in_tdata = 8'd0;
  logic        in_tuser = 1'b0;
  logic        out_tready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [31:0] cfg_data = 32'd0;
  wire         in_tready;
  wire         out_tvalid;
  wire  [39:0] out_tdata;
  wire  [6:0]  out_tuser;
  wire         out_tlast;
  wire         cfg_ready;

  length_prefixed_request_deframer_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // parser model state
  lprd_pkg::phase_t p_phase;
  logic [31:0]      p_acc;
  logic [1:0]       p_fcnt;
  logic [31:0]      p_body_left;
  logic [31:0]      p_strings_left;
  logic [31:0]      p_string_idx;
  logic [31:0]      p_string_left;
  logic             p_overrun;
  logic             p_closed;
  logic [31:0]      p_max_len;

  tag_t       tags_due[$];
  logic [7:0] frame[$];
  int         errors = 0;
  int         beats_sent = 0;
  int         quiet = 0;
  bit         steady = 1'b0;

  task automatic report(input string what);
    if (errors < ReportCap) $display("mismatch: %s", what);
    errors++;
  endtask

  function automatic void clear_parse();
    p_phase        = lprd_pkg::PH_HEADER;
    p_acc          = 32'd0;
    p_fcnt         = 2'd0;
    p_body_left    = 32'd0;
    p_strings_left = 32'd0;
    p_string_idx   = 32'd0;
    p_string_left  = 32'd0;
    p_overrun      = 1'b0;
    p_closed       = 1'b0;
  endfunction

  // Shift one byte into the little-endian field; true once four are in.
  function automatic bit take_field(input logic [7:0] b);
    p_acc = p_acc | ({24'd0, b} << (8 * p_fcnt));
    if (p_fcnt == 2'd3) begin
      p_fcnt = 2'd0;
      return 1'b1;
    end
    p_fcnt = p_fcnt + 2'd1;
    return 1'b0;
  endfunction

  function automatic void finish_string();
    p_string_idx   = p_string_idx + 32'd1;
    p_strings_left = p_strings_left - 32'd1;
    p_phase        = (p_strings_left == 32'd0) ? lprd_pkg::PH_DONE : lprd_pkg::PH_SLEN;
  endfunction

  function automatic void tag_byte(input logic [7:0] b, input logic rs);
    tag_t        t;
    logic [31:0] v;
    t.data     = b;
    t.kind     = lprd_pkg::KIND_BODY_LEN;
    t.idx      = 32'd0;
    t.str_last = 1'b0;
    t.msg_last = 1'b0;
    t.verd     = lprd_pkg::VERD_PROGRESS;
    if (rs) clear_parse();
    if (p_closed) begin
      t.kind = lprd_pkg::KIND_DROP;
      t.verd = lprd_pkg::VERD_DROPPED;
    end else if (p_phase == lprd_pkg::PH_HEADER) begin
      if (take_field(b)) begin
        v     = p_acc;
        p_acc = 32'd0;
        if (v > p_max_len) begin
          t.verd   = lprd_pkg::VERD_OVERSIZE;
          p_closed = 1'b1;
        end else if (v == 32'd0) begin
          t.msg_last = 1'b1;
          t.verd     = lprd_pkg::VERD_MALFORMED;
          p_closed   = 1'b1;
        end else begin
          p_body_left = v;
          p_phase     = lprd_pkg::PH_COUNT;
        end
      end
    end else begin
      case (p_phase)
        lprd_pkg::PH_COUNT: begin
          t.kind = lprd_pkg::KIND_COUNT;
          if (take_field(b)) begin
            p_strings_left = p_acc;
            p_acc          = 32'd0;
            p_string_idx   = 32'd0;
            p_phase        = (p_strings_left == 32'd0) ? lprd_pkg::PH_DONE
                                                        : lprd_pkg::PH_SLEN;
          end
        end
        lprd_pkg::PH_SLEN: begin
          t.kind = lprd_pkg::KIND_STR_LEN;
          t.idx  = p_string_idx;
          if (take_field(b)) begin
            p_string_left = p_acc;
            p_acc         = 32'd0;
            if (p_string_left == 32'd0) finish_string();
            else p_phase = lprd_pkg::PH_SDATA;
          end
        end
        lprd_pkg::PH_SDATA: begin
          t.kind        = lprd_pkg::KIND_STR_DATA;
          t.idx         = p_string_idx;
          p_string_left = p_string_left - 32'd1;
          if (p_string_left == 32'd0) begin
            t.str_last = 1'b1;
            finish_string();
          end
        end
        default: begin
          t.kind    = lprd_pkg::KIND_TRAIL;
          p_overrun = 1'b1;
        end
      endcase
      p_body_left = p_body_left - 32'd1;
      if (p_body_left == 32'd0) begin
        t.msg_last = 1'b1;
        if (p_phase == lprd_pkg::PH_DONE && !p_overrun) begin
          t.verd = lprd_pkg::VERD_WELL;
          clear_parse();
        end else begin
          t.verd   = lprd_pkg::VERD_MALFORMED;
          p_closed = 1'b1;
        end
      end
    end
    tags_due.insert(tags_due.size(), t);
  endfunction

  // Predict on every accepted byte, then compare every accepted result beat.
  always @(posedge clk) begin : scoreboard
    tag_t e;
    if (rst_n) begin
      if (in_tvalid && in_tready) tag_byte(in_tdata, in_tuser);
      if (out_tvalid && out_tready) begin
        if (tags_due.size() == 0) begin
          report("result beat with nothing expected");
        end else begin
          e = tags_due.pop_front();
          if (out_tdata[7:0] !== e.data)
            report($sformatf("byte_out %h, expected %h", out_tdata[7:0], e.data));
          if (out_tuser[2:0] !== e.kind)
            report($sformatf("byte_kind %0d, expected %0d", out_tuser[2:0], e.kind));
          if (out_tdata[39:8] !== e.idx)
            report($sformatf("string_number %0d, expected %0d", out_tdata[39:8], e.idx));
          if (out_tuser[3] !== e.str_last)
            report($sformatf("string_end %b, expected %b", out_tuser[3], e.str_last));
          if (out_tlast !== e.msg_last)
            report($sformatf("message_end %b, expected %b", out_tlast, e.msg_last));
          if (out_tuser[6:4] !== e.verd)
            report($sformatf("verdict %0d, expected %0d", out_tuser[6:4], e.verd));
        end
      end
    end
  end

  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99, 0) >= 25);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
        quiet <= 0;
      end else if (quiet >= IdleLimit) begin
        $display("testbench: errors");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic rs);
    while (!steady && $urandom_range(99, 0) < 25) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= rs;
    do @(posedge clk); while (!in_tready);
    beats_sent++;
  endtask

  // Drop valid and wait until every tagged beat has come back.
  task automatic settle();
    in_tvalid <= 1'b0;
    in_tuser  <= 1'b0;
    @(posedge clk);
    while (tags_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_max_len(input logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    p_max_len = v;
  endtask

  function automatic void push_le(input logic [31:0] w);
    for (int k = 0; k < 4; k++) frame.insert(frame.size(), w[8*k +: 8]);
  endfunction

  task automatic send_frame(input bit rs_first);
    foreach (frame[k]) send_byte(frame[k], rs_first && k == 0);
    frame.delete();
  endtask

  // Fill the frame with a request of random strings; return the declared body length.
  function automatic logic [31:0] build_request(input int nstr, input int longest,
                                                input flaw_t flaw);
    int          lens[$];
    int          body;
    int          extra;
    logic [31:0] declared;
    body = 4;
    for (int i = 0; i < nstr; i++) begin
      lens.insert(lens.size(), int'($urandom_range(longest, 0)));
      body += 4 + lens[i];
    end
    extra = $urandom_range(3, 1);
    case (flaw)
      FLAW_TRAIL:  declared = body + extra;
      FLAW_SHORT:  declared = body - extra;
      FLAW_LENGTH: declared = $urandom;
      default:     declared = body;
    endcase
    push_le(declared);
    if (flaw == FLAW_COUNT) push_le($urandom);
    else push_le(nstr);
    foreach (lens[i]) begin
      push_le(lens[i]);
      repeat (lens[i]) frame.insert(frame.size(), 8'($urandom_range(255, 0)));
    end
    if (flaw == FLAW_TRAIL)
      repeat (extra) frame.insert(frame.size(), 8'($urandom_range(255, 0)));
    return declared;
  endfunction

  task automatic test_well_formed();
    // two strings, one with extreme data bytes, one empty
    push_le(32'd14);
    push_le(32'd2);
    push_le(32'd2);
    frame.insert(frame.size(), 8'h00);
    frame.insert(frame.size(), 8'hFF);
    push_le(32'd0);
    send_frame(1'b0);
    // zero string count completes right after the count
    push_le(32'd4);
    push_le(32'd0);
    send_frame(1'b0);
    settle();
  endtask

  task automatic test_bad_bodies();
    // trailing bytes after the last string, then the closed parser drops
    push_le(32'd6);
    push_le(32'd0);
    frame.insert(frame.size(), 8'h5A);
    frame.insert(frame.size(), 8'hA5);
    send_frame(1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    // body ends inside the first string length
    push_le(32'd5);
    push_le(32'd1);
    push_le(32'd3);
    send_frame(1'b1);
    // empty body
    push_le(32'd0);
    send_frame(1'b1);
    // huge string count cannot complete inside the body
    push_le(32'd8);
    push_le(32'hFFFF_FFFF);
    push_le(32'd0);
    send_frame(1'b1);
    // restart in the middle of a header
    send_byte(8'h10, 1'b1);
    send_byte(8'h00, 1'b0);
    push_le(32'd9);
    push_le(32'd1);
    push_le(32'd1);
    frame.insert(frame.size(), 8'h80);
    send_frame(1'b1);
    settle();
  endtask

  task automatic test_size_limit();
    push_le(lprd_pkg::MaxMsgDefault + 32'd1);
    send_frame(1'b1);
    send_byte(8'h7E, 1'b0);
    push_le(lprd_pkg::MaxMsgDefault);
    send_frame(1'b1);
    settle();
    set_max_len(32'd0);
    push_le(32'd1);
    send_frame(1'b1);
    push_le(32'd0);
    send_frame(1'b1);
    settle();
    // body length equal to the limit passes, one above is refused
    set_max_len(32'd8);
    push_le(32'd8);
    push_le(32'd1);
    push_le(32'd0);
    send_frame(1'b1);
    push_le(32'd9);
    send_frame(1'b0);
    settle();
    set_max_len(32'hFFFF_FFFF);
    push_le(32'hFFFF_FFFF);
    send_frame(1'b1);
    push_le(32'd4);
    push_le(32'd0);
    send_frame(1'b1);
    settle();
  endtask

  task automatic test_random_traffic(input int per_round);
    bit          need_rs;
    int          r;
    int          target;
    flaw_t       flaw;
    logic [31:0] declared;
    need_rs = 1'b1;
    for (int round = 0; round < 4; round++) begin
      settle();
      case (round)
        0:       set_max_len(lprd_pkg::MaxMsgDefault);
        1:       set_max_len($urandom_range(160, 24));
        2:       set_max_len(32'hFFFF_FFFF);
        default: set_max_len($urandom);
      endcase
      steady = (round == 2);
      target = beats_sent + per_round;
      while (beats_sent < target) begin
        r = $urandom_range(99, 0);
        if (r < 12) begin
          repeat ($urandom_range(12, 1))
            send_byte($urandom_range(255, 0), $urandom_range(9, 0) == 0);
          need_rs = 1'b1;
        end else begin
          flaw     = (r < 75) ? FLAW_NONE : flaw_t'($urandom_range(4, 1));
          declared = build_request($urandom_range(4, 0), (r % 5 == 0) ? 40 : 6, flaw);
          send_frame(need_rs || $urandom_range(4, 0) == 0);
          need_rs = (flaw != FLAW_NONE) || (declared > p_max_len);
        end
      end
      steady = 1'b0;
    end
  endtask

  initial begin
    clear_parse();
    p_max_len = lprd_pkg::MaxMsgDefault;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_well_formed();
    test_bad_bodies();
    test_size_limit();
    test_random_traffic(150);
    settle();
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
